>>> hw/rtl/frame_table_second_chance_core_defines.svh
// Assertion macros for the frame table
`ifndef FRAME_TABLE_SECOND_CHANCE_CORE_DEFINES_SVH
`define FRAME_TABLE_SECOND_CHANCE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FT_ASSERT_IMP(label, clk, rst_n, a, c)
`define FT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/ftsc_pkg.sv
`default_nettype none
package ftsc_pkg;
    localparam int TableEntries = 64;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_MAP    = 3'd2;
    localparam logic [2:0] CMD_TOUCH  = 3'd3;
    localparam logic [2:0] CMD_EVICT  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [19:0] frame_number;
        logic [15:0] owner_id;
        logic [19:0] user_page;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] frame_out;
        logic [15:0] victim_owner;
        logic [19:0] victim_page;
        logic        victim_mapped;
    } rsp_t;

    // One table entry: frame, owner, page, mapped, accessed
    typedef struct packed {
        logic [19:0] frame;
        logic [15:0] owner;
        logic [19:0] page;
        logic        mapped;
        logic        accessed;
    } entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/frame_table_second_chance_core.sv
// Second-chance frame table.
// in: one request transaction (cmd, frame_number, owner_id, user_page) under
// in_valid/in_stall. out: one response transaction per request under
// out_valid/out_stall. One request is worked at a time; the table sits in a
// single-port-write, registered-read RAM, and entries are visited in turn.
// An add writes at the end of the table; map, touch and remove search from
// the front, and a remove then shifts the later entries down. An evict scans
// for an entry with a clear accessed bit, clearing the bits it passes; when
// every entry was touched it takes the front entry on the second pass. The
// victim is then shifted out and its frame appended with the new owner.
// The response is held in an output register; a new request is taken once
// it is handed over, and the block simply waits while out_stall is high.
// Reset empties the table at once (count cleared); no clearing pass is needed
// since only entries below the count are ever used.
`default_nettype none
`include "frame_table_second_chance_core_defines.svh"
module frame_table_second_chance_core #(
    parameter int TABLE_ENTRIES = ftsc_pkg::TableEntries
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire ftsc_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output ftsc_pkg::rsp_t     out_data
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(ftsc_pkg::entry_t);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_RESP
    } state_t;

    state_t          state_reg;
    ftsc_pkg::req_t  req_reg;
    ftsc_pkg::rsp_t  rsp_reg;
    ftsc_pkg::rsp_t  start_rsp;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;     // index whose data arrives this cycle (find, scan)
    logic            rd_pend_reg; // read of idx_reg was issued last cycle
    logic            pass_reg;
    logic            evict_reg;

    // RAM port signals
    logic             we;
    logic [AW-1:0]    waddr;
    ftsc_pkg::entry_t wdata;
    logic [AW-1:0]    raddr;
    ftsc_pkg::entry_t rdata;
    logic [EW-1:0]    rdata_raw;

    ftsc_ram #(.Width(EW), .Depth(TABLE_ENTRIES)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata_raw)
    );
    assign rdata = ftsc_pkg::entry_t'(rdata_raw);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign out_data  = rsp_reg;

    // Form the first response value for an incoming request
    always_comb
    begin
        start_rsp = '0;
        start_rsp.frame_out = in_data.frame_number;
        case (in_data.cmd)
            ftsc_pkg::CMD_ADD:
            begin
                if (count_reg >= FULL)
                begin
                    start_rsp.status = ftsc_pkg::ST_FULL;
                end
            end
            ftsc_pkg::CMD_REMOVE, ftsc_pkg::CMD_MAP, ftsc_pkg::CMD_TOUCH:
            begin
                if (count_reg == '0)
                begin
                    start_rsp.status = ftsc_pkg::ST_MISS;
                end
            end
            ftsc_pkg::CMD_EVICT:
            begin
                start_rsp.frame_out = '0;
                if (count_reg == '0)
                begin
                    start_rsp.status = ftsc_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                start_rsp.frame_out = '0;
            end
        endcase
    end

    // Drive RAM read and write for each state
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_FIND:
            begin
                if (rdata.frame == req_reg.frame_number && rd_pend_reg)
                begin
                    we = (req_reg.cmd == ftsc_pkg::CMD_MAP)
                        || (req_reg.cmd == ftsc_pkg::CMD_TOUCH);
                    if (req_reg.cmd == ftsc_pkg::CMD_MAP)
                    begin
                        wdata.page   = req_reg.user_page;
                        wdata.mapped = 1'b1;
                    end
                    else
                    begin
                        wdata.accessed = 1'b1;
                    end
                    raddr = AW'(idx_reg + CW'(1));
                end
                else
                begin
                    raddr = AW'(idx_reg + CW'(1));
                end
            end
            S_SCAN:
            begin
                // Clear the accessed bit of each entry passed on the first pass
                if (rd_pend_reg && rdata.accessed && !pass_reg)
                begin
                    we = 1'b1;
                    wdata.accessed = 1'b0;
                end
                raddr = (idx_reg + CW'(1) >= count_reg) ? AW'(0)
                                                         : AW'(idx_reg + CW'(1));
            end
            S_SHIFT_RD:
            begin
                raddr = AW'(idx_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wdata = rdata;
            end
            S_APPEND:
            begin
                we = 1'b1;
                waddr = AW'(count_reg - CW'(1));
                wdata.frame    = rsp_reg.frame_out;
                wdata.owner    = req_reg.owner_id;
                wdata.page     = '0;
                wdata.mapped   = 1'b0;
                wdata.accessed = 1'b0;
            end
            S_IDLE:
            begin
                we = in_valid && (in_data.cmd == ftsc_pkg::CMD_ADD)
                    && (count_reg < FULL);
                waddr = AW'(count_reg);
                wdata.frame    = in_data.frame_number;
                wdata.owner    = in_data.owner_id;
                wdata.page     = '0;
                wdata.mapped   = 1'b0;
                wdata.accessed = 1'b0;
                raddr = '0;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Sequencer: holds state, counters and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            req_reg     <= '0;
            rsp_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            pass_reg    <= 1'b0;
            evict_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg     <= in_data;
                        idx_reg     <= '0;
                        rd_pend_reg <= 1'b1;
                        pass_reg    <= 1'b0;
                        evict_reg   <= 1'b0;
                        rsp_reg     <= start_rsp;
                        case (in_data.cmd)
                            ftsc_pkg::CMD_ADD:
                            begin
                                state_reg <= S_RESP;
                                if (count_reg < FULL)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            ftsc_pkg::CMD_REMOVE, ftsc_pkg::CMD_MAP,
                            ftsc_pkg::CMD_TOUCH:
                            begin
                                state_reg <= (count_reg == '0) ? S_RESP : S_FIND;
                            end
                            ftsc_pkg::CMD_EVICT:
                            begin
                                state_reg <= (count_reg == '0) ? S_RESP : S_SCAN;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    // Compare entry at idx_reg; data valid this cycle
                    if (rdata.frame == req_reg.frame_number)
                    begin
                        if (req_reg.cmd == ftsc_pkg::CMD_REMOVE)
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                    else if (idx_reg + CW'(1) >= count_reg)
                    begin
                        rsp_reg.status <= ftsc_pkg::ST_MISS;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_SCAN:
                begin
                    // On the second pass every bit is clear: take the front entry
                    if (!rdata.accessed || pass_reg)
                    begin
                        rsp_reg <= '{status: ftsc_pkg::ST_OK,
                                     frame_out: rdata.frame,
                                     victim_owner: rdata.owner,
                                     victim_page: rdata.page,
                                     victim_mapped: rdata.mapped};
                        evict_reg <= 1'b1;
                        state_reg <= S_SHIFT_RD;
                    end
                    else if (idx_reg + CW'(1) >= count_reg)
                    begin
                        idx_reg  <= '0;
                        pass_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_SHIFT_RD:
                begin
                    // Read idx+1, to be written at idx
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        state_reg <= evict_reg ? S_APPEND : S_RESP;
                        if (!evict_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_APPEND:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FT_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= FULL)
    `FT_ASSERT_IMP(a_scan_in_table, clk, rst_n, state_reg == S_SCAN,
        idx_reg < count_reg)
    `FT_ASSERT_NXT(a_resp_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data))
    `FT_ASSERT_IMP(a_no_write_in_resp, clk, rst_n, state_reg == S_RESP, !we)
endmodule
`default_nettype wire

>>> hw/rtl/ftsc_ram.sv
`default_nettype none
module ftsc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> bench/frame_table_second_chance_core_test.sv
`default_nettype none
module frame_table_second_chance_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = ftsc_pkg::TableEntries;
    localparam int StallLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    ftsc_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    ftsc_pkg::rsp_t out_data;

    frame_table_second_chance_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #10 clk = ~clk;

    // Shadow of the frame table
    ftsc_pkg::entry_t table_q[$];
    ftsc_pkg::req_t   pending_reqs[$];
    ftsc_pkg::rsp_t   expected_rsps[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_recv = 1'b0;
    int     idle_cycles = 0;

    // Compute the response for one request and update the shadow table
    function automatic ftsc_pkg::rsp_t predict_frame_op(ftsc_pkg::req_t r);
        ftsc_pkg::rsp_t   rs;
        int               idx;
        int               victim;
        ftsc_pkg::entry_t e;
        rs = '0;
        idx = -1;
        victim = -1;
        if (r.cmd == ftsc_pkg::CMD_ADD)
        begin
            rs.frame_out = r.frame_number;
            if (table_q.size() >= Depth)
                rs.status = ftsc_pkg::ST_FULL;
            else
            begin
                e = '0;
                e.frame = r.frame_number;
                e.owner = r.owner_id;
                table_q.push_back(e);
            end
        end
        else if (r.cmd == ftsc_pkg::CMD_REMOVE || r.cmd == ftsc_pkg::CMD_MAP
                 || r.cmd == ftsc_pkg::CMD_TOUCH)
        begin
            rs.frame_out = r.frame_number;
            foreach (table_q[i])
                if (idx < 0 && table_q[i].frame == r.frame_number)
                    idx = i;
            if (idx < 0)
                rs.status = ftsc_pkg::ST_MISS;
            else if (r.cmd == ftsc_pkg::CMD_REMOVE)
                table_q.delete(idx);
            else if (r.cmd == ftsc_pkg::CMD_MAP)
            begin
                table_q[idx].page = r.user_page;
                table_q[idx].mapped = 1'b1;
            end
            else
                table_q[idx].accessed = 1'b1;
        end
        else if (r.cmd == ftsc_pkg::CMD_EVICT)
        begin
            for (int p = 0; p < 2 && victim < 0; p++)
                for (int i = 0; i < table_q.size() && victim < 0; i++)
                    if (!table_q[i].accessed)
                        victim = i;
                    else
                        table_q[i].accessed = 1'b0;
            if (victim < 0)
                rs.status = ftsc_pkg::ST_EMPTY;
            else
            begin
                e = table_q[victim];
                rs.frame_out = e.frame;
                rs.victim_owner = e.owner;
                rs.victim_page = e.page;
                rs.victim_mapped = e.mapped;
                table_q.delete(victim);
                e = '0;
                e.frame = rs.frame_out;
                e.owner = r.owner_id;
                table_q.push_back(e);
            end
        end
        return rs;
    endfunction

    // Driver: offer pending requests, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_rsps.push_back(predict_frame_op(in_data));
                void'(pending_reqs.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare responses and randomize stall
    always @(posedge clk)
    begin
        ftsc_pkg::rsp_t ex;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response %p", out_data);
                    errors++;
                end
                else
                begin
                    ex = expected_rsps.pop_front();
                    if (out_data.status !== ex.status)
                    begin
                        $error("status exp %0d got %0d", ex.status, out_data.status);
                        errors++;
                    end
                    if (out_data.frame_out !== ex.frame_out)
                    begin
                        $error("frame_out exp %0h got %0h", ex.frame_out, out_data.frame_out);
                        errors++;
                    end
                    if (out_data.victim_owner !== ex.victim_owner)
                    begin
                        $error("victim_owner exp %0h got %0h", ex.victim_owner,
                               out_data.victim_owner);
                        errors++;
                    end
                    if (out_data.victim_page !== ex.victim_page)
                    begin
                        $error("victim_page exp %0h got %0h", ex.victim_page,
                               out_data.victim_page);
                        errors++;
                    end
                    if (out_data.victim_mapped !== ex.victim_mapped)
                    begin
                        $error("victim_mapped exp %0d got %0d", ex.victim_mapped,
                               out_data.victim_mapped);
                        errors++;
                    end
                end
            end
            // Count cycles with no transaction on either channel
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
            if (idle_cycles >= StallLimit)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Pick a frame number, mostly one already in the shadow table
    function automatic logic [19:0] pick_frame(int hit_pct);
        if (table_q.size() > 0 && $urandom_range(99) < hit_pct)
            return table_q[$urandom_range(table_q.size() - 1)].frame;
        return 20'($urandom_range(63));
    endfunction

    function automatic ftsc_pkg::req_t make_req(logic [2:0] c, logic [19:0] f);
        ftsc_pkg::req_t r;
        r.cmd = c;
        r.frame_number = f;
        r.owner_id = 16'($urandom());
        r.user_page = 20'($urandom());
        return r;
    endfunction

    task automatic drain_all();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    initial
    begin
        ftsc_pkg::req_t r;
        int   shadow_cnt;
        int   roll;
        logic [2:0] c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, duplicates, touched entries, evicts, unused commands
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_EVICT, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_MAP, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, 20'h0));
        r = make_req(ftsc_pkg::CMD_ADD, 20'hFFFFF); r.owner_id = 16'hFFFF;
        pending_reqs.push_back(r);
        r = make_req(ftsc_pkg::CMD_ADD, 20'h0); r.owner_id = 16'h0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_ADD, 20'hFFFFF));
        r = make_req(ftsc_pkg::CMD_MAP, 20'hFFFFF); r.user_page = 20'hFFFFF;
        pending_reqs.push_back(r);
        r = make_req(ftsc_pkg::CMD_MAP, 20'h0); r.user_page = 20'h0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_EVICT, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_EVICT, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'hFFFFF));
        for (int k = 5; k < 8; k++)
            pending_reqs.push_back(make_req(3'(k), 20'hABCDE));
        drain_all();

        // Single entry, touched, then evicted
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'hFFFFF));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_ADD, 20'h12345));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, 20'h12345));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_EVICT, 20'h0));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_REMOVE, 20'h12345));
        drain_all();

        // Fill to the limit and overflow
        for (int k = 0; k < Depth + 2; k++)
            pending_reqs.push_back(make_req(ftsc_pkg::CMD_ADD, 20'(k)));
        pending_reqs.push_back(make_req(ftsc_pkg::CMD_EVICT, 20'h0));
        drain_all();

        // Random phases with varying idle and stall pressure
        shadow_cnt = Depth + 1;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 61 : 0;
            recv_stall_pct = (ph == 2) ? 61 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 15;
                recv_stall_pct = 15;
            end
            for (int n = 0; n < 200; n++)
            begin
                roll = $urandom_range(99);
                if (shadow_cnt < 8)
                    c = roll < 50 ? ftsc_pkg::CMD_ADD
                        : (roll < 70 ? ftsc_pkg::CMD_TOUCH : ftsc_pkg::CMD_EVICT);
                else if (shadow_cnt > Depth - 4)
                    c = roll < 30 ? ftsc_pkg::CMD_REMOVE
                        : (roll < 60 ? ftsc_pkg::CMD_TOUCH
                        : (roll < 70 ? ftsc_pkg::CMD_ADD
                        : (roll < 85 ? ftsc_pkg::CMD_EVICT : ftsc_pkg::CMD_MAP)));
                else
                    c = roll < 20 ? ftsc_pkg::CMD_ADD
                        : (roll < 32 ? ftsc_pkg::CMD_REMOVE
                        : (roll < 50 ? ftsc_pkg::CMD_MAP
                        : (roll < 75 ? ftsc_pkg::CMD_TOUCH
                        : (roll < 97 ? ftsc_pkg::CMD_EVICT : 3'($urandom_range(5, 7))))));
                if (c == ftsc_pkg::CMD_ADD && shadow_cnt < Depth + 1) shadow_cnt++;
                if (c == ftsc_pkg::CMD_REMOVE && shadow_cnt > 0) shadow_cnt--;
                pending_reqs.push_back(make_req(c, pick_frame(85)));
                // Keep the shadow table close so hits stay frequent
                while (pending_reqs.size() > 4) @(posedge clk);
            end
            // Sender pauses here until all responses are back
            drain_all();
            if (ph == 0)
            begin
                // Long receiver hold-off while the sender keeps offering
                hold_recv = 1'b1;
                for (int k = 0; k < 12; k++)
                    pending_reqs.push_back(make_req(ftsc_pkg::CMD_TOUCH, pick_frame(90)));
                repeat (600) @(posedge clk);
                hold_recv = 1'b0;
                drain_all();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
